// ----- sv/delta_nibble_rle_decoder_core_defines.svh -----
// Assertion macros used by the delta nibble RLE decoder checker
`ifndef DELTA_NIBBLE_RLE_DECODER_CORE_DEFINES_SVH
`define DELTA_NIBBLE_RLE_DECODER_CORE_DEFINES_SVH

// clocked on i_clk, quiet while i_rst_n is low
`define DNRD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dnrd assertion failed");

// clocked on i_clk, also checked during reset
`define DNRD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("dnrd reset assertion failed");

`endif

// ----- sv/dnrd_pkg.sv -----
// Shared types and constants of the delta nibble RLE decoder
`default_nettype none

package dnrd_pkg;

    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = QPTR_W + 1;
    localparam int RUN_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_ABS = 2'd1,
        OP_END = 2'd2,
        OP_RUN = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] arg;
        logic       last;
    } t_entry;

endpackage

`default_nettype wire

// ----- sv/dnrd_if.sv -----
// Valid/ready channel interfaces of the delta nibble RLE decoder
`default_nettype none

interface dnrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface dnrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;
    logic       last;

    modport source (output valid, output data_byte, output block_end, output last,
                     input ready);
    modport sink   (input valid, input data_byte, input block_end, input last,
                     output ready);
endinterface

`default_nettype wire

// ----- sv/dnrd_fifo.sv -----
// Short operation queue between the decoder front and back ends
`default_nettype none

module dnrd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  dnrd_pkg::t_entry     i_entry,
    output logic                 o_ready,
    input  wire logic            i_pop,
    output dnrd_pkg::t_entry     o_entry,
    output logic                 o_valid
);

    dnrd_pkg::t_entry                r_mem [dnrd_pkg::QDEPTH];
    logic [dnrd_pkg::QPTR_W-1:0]     r_wptr;
    logic [dnrd_pkg::QPTR_W-1:0]     r_rptr;
    logic [dnrd_pkg::QCNT_W-1:0]     r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_ready = (r_count != dnrd_pkg::QCNT_W'(dnrd_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/dnrd_front.sv -----
// Front end: takes code bytes and turns their nibbles into queued operations
`default_nettype none

module dnrd_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dnrd_in_if.sink          i_in,
    output logic             o_push,
    output dnrd_pkg::t_entry o_entry,
    input  wire logic        i_q_ready
);

    typedef enum logic [4:0] {
        PEND_NONE  = 5'b00001,
        PEND_ABS_H = 5'b00010,
        PEND_ABS_L = 5'b00100,
        PEND_DELTA = 5'b01000,
        PEND_RUN   = 5'b10000
    } t_pend;

    typedef struct packed {
        logic          emit;
        dnrd_pkg::t_op op;
        logic [7:0]    arg;
        t_pend         pend;
        logic [3:0]    held;
    } t_nib_res;

    function automatic t_nib_res classify(t_pend p, logic [3:0] h, logic [3:0] n);
        t_nib_res r;
        r.emit = 1'b0;
        r.op   = dnrd_pkg::OP_ADD;
        r.arg  = 8'd0;
        r.pend = PEND_NONE;
        r.held = h;
        unique case (p)
            PEND_ABS_H: begin
                r.held = n;
                r.pend = PEND_ABS_L;
            end
            PEND_ABS_L: begin
                r.emit = 1'b1;
                r.op   = dnrd_pkg::OP_ABS;
                r.arg  = {h, n};
            end
            PEND_DELTA: begin
                r.emit = 1'b1;
                if (n == 4'd7) begin
                    r.op = dnrd_pkg::OP_END;
                end else if (n < 4'd7) begin
                    r.arg = {4'd0, n} + 8'd7;
                end else begin
                    r.arg = {4'd0, n} + 8'd234;
                end
            end
            PEND_RUN: begin
                r.emit = 1'b1;
                r.op   = dnrd_pkg::OP_RUN;
                r.arg  = {4'd0, n};
            end
            default: begin
                if (n == 4'd7) begin
                    r.pend = PEND_ABS_H;
                end else if (n == 4'd8) begin
                    r.pend = PEND_DELTA;
                end else if (n == 4'd9) begin
                    r.pend = PEND_RUN;
                end else begin
                    r.emit = 1'b1;
                    r.arg  = (n <= 4'd6) ? {4'd0, n} : {4'd0, n} + 8'd240;
                end
            end
        endcase
        return r;
    endfunction

    logic       r_full;
    logic       r_lo;
    logic [7:0] r_byte;
    t_pend      r_pend;
    logic [3:0] r_held;

    logic [3:0] nib;
    t_nib_res   c_cur;
    t_nib_res   c_nxt;
    logic       cur_end;
    logic       adv;
    logic       finish;
    logic       accept;

    assign nib     = r_lo ? r_byte[3:0] : r_byte[7:4];
    assign c_cur   = classify(r_pend, r_held, nib);
    assign c_nxt   = classify(c_cur.pend, c_cur.held, r_byte[3:0]);
    assign cur_end = c_cur.emit && (c_cur.op == dnrd_pkg::OP_END);
    assign adv     = r_full && (!c_cur.emit || i_q_ready);
    assign finish  = adv && (r_lo || cur_end);

    assign i_in.ready = !r_full || finish;
    assign accept     = i_in.valid && i_in.ready;

    assign o_push     = adv && c_cur.emit;
    assign o_entry.op   = c_cur.op;
    assign o_entry.arg  = c_cur.arg;
    assign o_entry.last = r_lo || cur_end || !c_nxt.emit;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.code_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_lo   <= 1'b0;
            r_pend <= PEND_NONE;
            r_held <= 4'd0;
        end else begin
            if (adv) begin
                r_pend <= c_cur.pend;
                r_held <= c_cur.held;
                if (!finish) begin
                    r_lo <= 1'b1;
                end
            end
            if (accept) begin
                r_full <= 1'b1;
                r_lo   <= 1'b0;
            end else if (finish) begin
                r_full <= 1'b0;
                r_lo   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/dnrd_back.sv -----
// Back end: runs queued operations and drives the registered result channel
`default_nettype none

module dnrd_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  dnrd_pkg::t_entry i_entry,
    input  wire logic        i_q_valid,
    output logic             o_pop,
    dnrd_out_if.source       o_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                         r_state;
    logic                           r_out_valid;
    logic [7:0]                     r_data;
    logic                           r_end;
    logic                           r_last;
    logic [7:0]                     r_last_value;
    logic [dnrd_pkg::RUN_CNT_W-1:0] r_cnt;
    logic                           r_run_last;

    logic       out_load;
    logic [7:0] sum;

    assign out_load = !r_out_valid || o_out.ready;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid && out_load;
    assign sum      = r_last_value + i_entry.arg;

    assign o_out.valid     = r_out_valid;
    assign o_out.data_byte = r_data;
    assign o_out.block_end = r_end;
    assign o_out.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_last_value <= 8'd0;
            r_cnt        <= '0;
            r_run_last   <= 1'b0;
            r_data       <= 8'd0;
            r_end        <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_out_valid <= 1'b1;
                        r_end       <= 1'b0;
                        r_last      <= i_entry.last;
                        unique case (i_entry.op)
                            dnrd_pkg::OP_ADD: begin
                                r_data       <= sum;
                                r_last_value <= sum;
                            end
                            dnrd_pkg::OP_ABS: begin
                                r_data       <= i_entry.arg;
                                r_last_value <= i_entry.arg;
                            end
                            dnrd_pkg::OP_END: begin
                                r_data <= 8'd0;
                                r_end  <= 1'b1;
                            end
                            dnrd_pkg::OP_RUN: begin
                                r_data     <= r_last_value;
                                r_last     <= 1'b0;
                                r_cnt      <= dnrd_pkg::RUN_CNT_W'(i_entry.arg[3:0])
                                              + dnrd_pkg::RUN_CNT_W'(2);
                                r_run_last <= i_entry.last;
                                r_state    <= ST_RUN;
                            end
                        endcase
                    end else if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_data      <= r_last_value;
                        r_end       <= 1'b0;
                        r_last      <= r_run_last && (r_cnt == dnrd_pkg::RUN_CNT_W'(1));
                        r_cnt       <= r_cnt - 1'b1;
                        if (r_cnt == dnrd_pkg::RUN_CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/delta_nibble_rle_decoder_core.sv -----
// Top level of the delta nibble RLE decoder
// Usage:
//   i_in carries one compressed code byte per transaction; its high nibble is
//   decoded first, then its low nibble. o_out carries decoded bytes, one per
//   transaction, with block_end marking the end-of-block item (data_byte 0)
//   and last marking the final result caused by an input byte.
//   A result passes the code byte register, the operation queue and the
//   output register. The front end takes the next code byte in the same
//   cycle as it finishes the current one; a nibble that emits waits for queue room.
//   A repeat code with count nibble n holds the back end for n+3 output bytes;
//   meanwhile the 4-entry operation queue fills and then stalls input.
//   Bytes that only feed a pending code produce no results.
//   Reset (synchronous, active low): the last decoded byte becomes 0, no code
//   is pending, the queue is emptied and o_out.valid drops.
//   A stalled receiver holds the output register; the queue absorbs a few
//   operations before i_in.ready falls.
`default_nettype none

module delta_nibble_rle_decoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dnrd_in_if.sink    i_in,
    dnrd_out_if.source o_out
);

    logic             q_push;
    logic             q_ready;
    logic             q_pop;
    logic             q_valid;
    dnrd_pkg::t_entry q_in;
    dnrd_pkg::t_entry q_out;

    dnrd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_push    (q_push),
        .o_entry   (q_in),
        .i_q_ready (q_ready)
    );

    dnrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_valid (q_valid)
    );

    dnrd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (q_out),
        .i_q_valid (q_valid),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ----- sv/dnrd_checker.sv -----
// Port-level checker of the delta nibble RLE decoder, bound to the top level
`default_nettype none
`include "delta_nibble_rle_decoder_core_defines.svh"

module dnrd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_data_byte,
    input wire logic       i_out_block_end,
    input wire logic       i_out_last
);

    `DNRD_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data_byte) && $stable(i_out_block_end) && $stable(i_out_last))
    `DNRD_ASSERT(a_end_is_last, i_out_valid && i_out_block_end |-> i_out_last)
    `DNRD_ASSERT(a_end_no_data, i_out_valid && i_out_block_end |-> i_out_data_byte == 8'd0)
    `DNRD_ASSERT_RST(a_reset_clears, !i_rst_n |=> !i_out_valid)

endmodule

bind delta_nibble_rle_decoder_core dnrd_checker u_dnrd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_data_byte (o_out.data_byte),
    .i_out_block_end (o_out.block_end),
    .i_out_last      (o_out.last)
);

`default_nettype wire
